// File: sv/stv_pkg.sv
// shared types, constants and helpers for the sample timestamp validator
package stv_pkg;

  localparam int unsigned StampW = 63;
  localparam int unsigned UsW    = 64;
  localparam int unsigned NowW   = 64;
  localparam int unsigned GenW   = 64;
  localparam int unsigned EventW = 4;
  localparam int unsigned CfgIdxW = 2;

  // largest microsecond stamp whose ns value fits in 63 bits
  localparam logic [UsW-1:0] MaxUs = 64'd9223372036854775;
  localparam logic [GenW-1:0] GenMax = '1;

  localparam logic [StampW-1:0] RestartMinRst = 63'd1000000000;
  localparam logic [StampW-1:0] LowEpochRst   = 63'd60000000000;
  localparam logic [StampW-1:0] StaleRst      = 63'd500000000;
  localparam logic [StampW-1:0] FutureRst     = 63'd100000000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESTART_MIN = 2'd0,
    CFG_LOW_EPOCH   = 2'd1,
    CFG_STALE       = 2'd2,
    CFG_FUTURE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [EventW-1:0] {
    EV_ACCEPTED  = 4'd0,
    EV_BAD_NOW   = 4'd1,
    EV_BAD_CONV  = 4'd2,
    EV_EXHAUSTED = 4'd3,
    EV_DUPLICATE = 4'd4,
    EV_SMALL_REG = 4'd5,
    EV_RESTART   = 4'd6,
    EV_STALE     = 4'd7,
    EV_FUTURE    = 4'd8
  } event_e;

  // item class decided by the front end
  typedef enum logic [1:0] {
    KIND_OBSERVE  = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_BAD_NOW  = 2'd2,
    KIND_BAD_CONV = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [StampW-1:0] ts_ns;
    logic [StampW-1:0] now_ns;
  } entry_t;

  typedef struct packed {
    logic [StampW-1:0] restart_min;
    logic [StampW-1:0] low_epoch;
    logic [StampW-1:0] stale;
    logic [StampW-1:0] future;
  } cfg_t;

  // times 1000 as 1024 - 16 - 8, by shifts and adds
  function automatic logic [StampW-1:0] mul1000(input logic [UsW-1:0] us);
    logic [UsW-1:0] prod;
    prod = (us << 10) - (us << 4) - (us << 3);
    return prod[StampW-1:0];
  endfunction

endpackage

// File: sv/stv_in_if.sv
// input item channel
interface stv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    operation;
  logic        [stv_pkg::UsW-1:0]          stamp_us;
  logic signed [stv_pkg::NowW-1:0]         now_ns;

  modport source (output valid, operation, stamp_us, now_ns, input ready);
  modport sink   (input valid, operation, stamp_us, now_ns, output ready);
endinterface

// File: sv/stv_out_if.sv
// result item channel
interface stv_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [stv_pkg::GenW-1:0]      generation;
  logic [stv_pkg::EventW-1:0]    event_res;

  modport source (output valid, accepted, generation, event_res, input ready);
  modport sink   (input valid, accepted, generation, event_res, output ready);
endinterface

// File: sv/stv_cfg_if.sv
// configuration write channel
interface stv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [stv_pkg::CfgIdxW-1:0]   reg_index;
  logic [stv_pkg::StampW-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// File: sv/stv_front.sv
// front end: classifies an input item and converts its stamp to ns
module stv_front (
  input  logic                          operation_i,
  input  logic        [stv_pkg::UsW-1:0]  stamp_us_i,
  input  logic signed [stv_pkg::NowW-1:0] now_ns_i,
  output stv_pkg::entry_t               entry_o
);

  logic bad_now;
  logic bad_conv;

  assign bad_now  = now_ns_i[stv_pkg::NowW-1] || (now_ns_i == '0);
  assign bad_conv = (stamp_us_i == '0) || (stamp_us_i > stv_pkg::MaxUs);

  always_comb begin
    entry_o.ts_ns  = stv_pkg::mul1000(stamp_us_i);
    entry_o.now_ns = now_ns_i[stv_pkg::StampW-1:0];
    if (operation_i) begin
      entry_o.kind = stv_pkg::KIND_CLEAR;
    end else if (bad_now) begin
      entry_o.kind = stv_pkg::KIND_BAD_NOW;
    end else if (bad_conv) begin
      entry_o.kind = stv_pkg::KIND_BAD_CONV;
    end else begin
      entry_o.kind = stv_pkg::KIND_OBSERVE;
    end
  end

endmodule

// File: sv/stv_queue.sv
// two-entry queue between front end and back end
module stv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  stv_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output stv_pkg::entry_t pop_entry_o
);

  stv_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: sv/stv_back.sv
// back end: history and window checks, state update, output register
module stv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stv_pkg::cfg_t     cfg_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  stv_pkg::entry_t   q_entry_i,
  stv_out_if.source         out_o
);

  logic [stv_pkg::StampW-1:0] last_q, last_d;
  logic                       have_q, have_d;
  logic [stv_pkg::GenW-1:0]   gen_q, gen_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_acc_q;
  logic [stv_pkg::GenW-1:0]   out_gen_q;
  stv_pkg::event_e            out_ev_q;

  logic                       pop;
  logic                       emit;
  logic                       acc;
  stv_pkg::event_e            ev;
  logic [stv_pkg::StampW-1:0] ts;
  logic [stv_pkg::StampW-1:0] now;
  logic [stv_pkg::StampW-1:0] back_amt;
  logic [stv_pkg::StampW-1:0] age;
  logic [stv_pkg::StampW-1:0] lead;
  logic                       restart;
  logic                       stale;
  logic                       future;

  assign ts  = q_entry_i.ts_ns;
  assign now = q_entry_i.now_ns;

  // all differences in parallel, each followed by one compare
  assign back_amt = last_q - ts;
  assign age      = now - ts;
  assign lead     = ts - now;
  assign restart  = (back_amt >= cfg_i.restart_min) && (last_q > cfg_i.low_epoch)
                    && (ts <= cfg_i.low_epoch);
  assign stale    = (now > ts) && (age > cfg_i.stale);
  assign future   = (ts > now) && (lead > cfg_i.future);

  // a clear needs no output slot
  assign q_ready_o = (q_entry_i.kind == stv_pkg::KIND_CLEAR) || !out_valid_q || out_o.ready;
  assign pop = q_valid_i && q_ready_o;

  always_comb begin
    last_d = last_q;
    have_d = have_q;
    gen_d  = gen_q;
    emit   = 1'b0;
    acc    = 1'b0;
    ev     = stv_pkg::EV_ACCEPTED;
    if (pop) begin
      unique case (q_entry_i.kind)
        stv_pkg::KIND_CLEAR: begin
          have_d = 1'b0;
          if (gen_q != stv_pkg::GenMax) begin
            gen_d = gen_q + 1'b1;
          end
        end
        stv_pkg::KIND_BAD_NOW: begin
          emit = 1'b1;
          ev   = stv_pkg::EV_BAD_NOW;
        end
        stv_pkg::KIND_BAD_CONV: begin
          emit = 1'b1;
          ev   = stv_pkg::EV_BAD_CONV;
        end
        stv_pkg::KIND_OBSERVE: begin
          emit = 1'b1;
          if (have_q && (ts <= last_q)) begin
            if (ts == last_q) begin
              ev = stv_pkg::EV_DUPLICATE;
            end else if (restart) begin
              if (gen_q == stv_pkg::GenMax) begin
                ev = stv_pkg::EV_EXHAUSTED;
              end else begin
                gen_d  = gen_q + 1'b1;
                last_d = ts;
                acc    = 1'b1;
                ev     = stv_pkg::EV_RESTART;
              end
            end else begin
              ev = stv_pkg::EV_SMALL_REG;
            end
          end else if (stale) begin
            ev = stv_pkg::EV_STALE;
          end else if (future) begin
            ev = stv_pkg::EV_FUTURE;
          end else begin
            last_d = ts;
            have_d = 1'b1;
            acc    = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (emit) begin
      out_acc_q <= acc;
      out_gen_q <= gen_d;
      out_ev_q  <= ev;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.accepted   = out_acc_q;
  assign out_o.generation = out_gen_q;
  assign out_o.event_res  = out_ev_q;

endmodule

// File: sv/sample_timestamp_validator_top.sv
// sample timestamp validator: front end, queue, back end and config registers
// path: each item is held in the queue; its result is then held in the output register
// throughput: one item per cycle unless output stalls; compares feed the state update
// a clear item gives no result and passes the back end even while the output waits
// reset: async active low; empties the queue and output, forgets the last stamp,
// zeroes the generation and loads the default window and restart limits
module sample_timestamp_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  stv_in_if.sink     in_ch_i,
  stv_out_if.source  out_ch_o,
  stv_cfg_if.sink    cfg_ch_i
);

  stv_pkg::cfg_t   cfg_q;
  stv_pkg::entry_t front_entry;
  stv_pkg::entry_t q_entry;
  logic            q_valid;
  logic            q_ready;

  // config writes are always taken
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restart_min <= stv_pkg::RestartMinRst;
      cfg_q.low_epoch   <= stv_pkg::LowEpochRst;
      cfg_q.stale       <= stv_pkg::StaleRst;
      cfg_q.future      <= stv_pkg::FutureRst;
    end else if (cfg_ch_i.valid) begin
      unique case (stv_pkg::cfg_idx_e'(cfg_ch_i.reg_index))
        stv_pkg::CFG_RESTART_MIN: cfg_q.restart_min <= cfg_ch_i.data;
        stv_pkg::CFG_LOW_EPOCH:   cfg_q.low_epoch   <= cfg_ch_i.data;
        stv_pkg::CFG_STALE:       cfg_q.stale       <= cfg_ch_i.data;
        stv_pkg::CFG_FUTURE:      cfg_q.future      <= cfg_ch_i.data;
        default:                  cfg_q             <= cfg_q;
      endcase
    end
  end

  // classify and convert to ns before queueing
  stv_front u_front (
    .operation_i    (in_ch_i.operation),
    .stamp_us_i     (in_ch_i.stamp_us),
    .now_ns_i       (in_ch_i.now_ns),
    .entry_o        (front_entry)
  );

  // the queue decouples input transfers from output stalls
  stv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_ch_i.valid),
    .push_ready_o (in_ch_i.ready),
    .push_entry_i (front_entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_entry_o  (q_entry)
  );

  // history state and result register
  stv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_entry_i (q_entry),
    .out_o     (out_ch_o)
  );

endmodule

// File: test/sample_timestamp_validator_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench: random and directed samples, window settings, result scoreboard
module sample_timestamp_validator_top_tb;

  localparam logic                       OpObserve  = 1'b0;
  localparam logic                       OpClear    = 1'b1;
  localparam logic [stv_pkg::UsW-1:0]    NsPerUs    = 64'd1000;
  localparam logic [stv_pkg::StampW-1:0] StampMax   = '1;
  localparam int unsigned                MaxReports = 10;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned                LongHold   = 300;
  // tail after the last result, before the final check
  localparam int unsigned                TailCycles = 20;
  // idle cycles before a register write, clear items give no result to wait for
  localparam int unsigned                IdleCycles = 4;

  typedef struct packed {
    logic                            op;
    logic [stv_pkg::UsW-1:0]         ts_us;
    logic signed [stv_pkg::NowW-1:0] now;
  } sample_t;

  typedef struct packed {
    logic                     accepted;
    logic [stv_pkg::GenW-1:0] generation;
    stv_pkg::event_e          ev;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  stv_in_if  in_ch ();
  stv_out_if out_ch ();
  stv_cfg_if cfg_ch ();

  sample_timestamp_validator_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  // own copy of the window registers and history
  logic [stv_pkg::StampW-1:0] win_restart_min;
  logic [stv_pkg::StampW-1:0] win_low_epoch;
  logic [stv_pkg::StampW-1:0] win_stale;
  logic [stv_pkg::StampW-1:0] win_future;
  logic [stv_pkg::StampW-1:0] hist_last_ns;
  logic                       hist_have_last;
  logic [stv_pkg::GenW-1:0]   hist_gen;

  sample_t  pending_samples[$];
  verdict_t expected_verdicts[$];

  int unsigned samples_queued;
  int unsigned samples_taken;
  int unsigned verdicts_checked;
  int unsigned reg_writes;
  int unsigned mismatches;
  int unsigned event_hits[9];

  // pacing controls, set by the stimulus process
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned stall_req;

  // driver and receiver private counters
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold;
  int unsigned stall_seen;
  logic        in_fire;

  // synthetic time base for the well-formed stream
  logic [stv_pkg::UsW-1:0] stream_now;
  logic [stv_pkg::UsW-1:0] stream_last_us;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // safety net against a hung handshake
  initial begin
    #2_000_000;
    $display("sample_timestamp_validator_top regression: fail");
    $finish;
  end

  // mostly back-to-back, now and then a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // verdict for one transfer; updates the history, returns 0 when no result follows
  function automatic bit predict_validation(input sample_t s, output verdict_t v);
    logic [stv_pkg::UsW-1:0] ts;
    logic [stv_pkg::UsW-1:0] now_u;
    logic [stv_pkg::UsW-1:0] last_u;
    v = '0;
    now_u = s.now;
    if (s.op == OpClear) begin
      hist_have_last = 1'b0;
      if (hist_gen != stv_pkg::GenMax) hist_gen = hist_gen + 1'b1;
      return 1'b0;
    end
    ts = '0;
    if (now_u[stv_pkg::NowW-1] || now_u == '0) begin
      v.ev = stv_pkg::EV_BAD_NOW;
    end else if (s.ts_us == '0 || s.ts_us > stv_pkg::MaxUs) begin
      v.ev = stv_pkg::EV_BAD_CONV;
    end else begin
      ts = s.ts_us * NsPerUs;
      last_u = {1'b0, hist_last_ns};
      if (hist_have_last && ts <= last_u) begin
        if (ts == last_u) begin
          v.ev = stv_pkg::EV_DUPLICATE;
        end else if ((last_u - ts) >= {1'b0, win_restart_min} &&
                     last_u > {1'b0, win_low_epoch} && ts <= {1'b0, win_low_epoch}) begin
          // the generation can't saturate in a run of this length, so exhaustion stays idle
          if (hist_gen == stv_pkg::GenMax) begin
            v.ev = stv_pkg::EV_EXHAUSTED;
          end else begin
            hist_gen = hist_gen + 1'b1;
            hist_last_ns = ts[stv_pkg::StampW-1:0];
            v.accepted = 1'b1;
            v.ev = stv_pkg::EV_RESTART;
          end
        end else begin
          v.ev = stv_pkg::EV_SMALL_REG;
        end
      end else if (now_u > ts && (now_u - ts) > {1'b0, win_stale}) begin
        v.ev = stv_pkg::EV_STALE;
      end else if (ts > now_u && (ts - now_u) > {1'b0, win_future}) begin
        v.ev = stv_pkg::EV_FUTURE;
      end else begin
        hist_last_ns = ts[stv_pkg::StampW-1:0];
        hist_have_last = 1'b1;
        v.accepted = 1'b1;
        v.ev = stv_pkg::EV_ACCEPTED;
      end
    end
    v.generation = hist_gen;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("mismatch: %s", msg);
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk_i) begin : scoreboard_proc
    sample_t  s;
    verdict_t v;
    verdict_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        s.op    = in_ch.operation;
        s.ts_us = in_ch.stamp_us;
        s.now   = in_ch.now_ns;
        samples_taken++;
        if (predict_validation(s, v)) expected_verdicts.push_back(v);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result acc=%0d gen=%0d ev=%0d",
                                    out_ch.accepted, out_ch.generation, out_ch.event_res));
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          event_hits[want.ev]++;
          if (out_ch.accepted !== want.accepted || out_ch.generation !== want.generation ||
              out_ch.event_res !== want.ev) begin
            report_mismatch($sformatf(
              "result %0d: exp acc=%0d gen=%0d ev=%0d, got acc=%0d gen=%0d ev=%0d",
              verdicts_checked, want.accepted, want.generation, want.ev,
              out_ch.accepted, out_ch.generation, out_ch.event_res));
          end
        end
      end
    end
  end

  // sender: presents the next pending sample once the previous one is taken
  always @(negedge clk_i) begin : sample_driver_proc
    sample_t s;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_ch.operation <= s.op;
        in_ch.stamp_us  <= s.ts_us;
        in_ch.now_ns    <= s.now;
        in_ch.valid     <= 1'b1;
        tx_gap = tx_idle_en ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus an on-demand long hold-off
  always @(negedge clk_i) begin : result_sink_proc
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      rx_hold = LongHold;
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rx_gap = rx_idle_en ? pick_gap() : 0;
    end
  end

  task automatic queue_sample(input logic op, input logic [stv_pkg::UsW-1:0] us,
                              input logic signed [stv_pkg::NowW-1:0] now);
    sample_t s;
    s.op = op;
    s.ts_us = us;
    s.now = now;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // every queued sample taken and every verdict back, then a few quiet cycles
  task automatic drain_results();
    while (samples_taken != samples_queued || expected_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input stv_pkg::cfg_idx_e idx,
                           input logic [stv_pkg::StampW-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      stv_pkg::CFG_RESTART_MIN: win_restart_min = val;
      stv_pkg::CFG_LOW_EPOCH:   win_low_epoch   = val;
      stv_pkg::CFG_STALE:       win_stale       = val;
      stv_pkg::CFG_FUTURE:      win_future      = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_window(input logic [stv_pkg::StampW-1:0] rmin,
                              input logic [stv_pkg::StampW-1:0] low,
                              input logic [stv_pkg::StampW-1:0] stale,
                              input logic [stv_pkg::StampW-1:0] fut);
    write_reg(stv_pkg::CFG_RESTART_MIN, rmin);
    write_reg(stv_pkg::CFG_LOW_EPOCH, low);
    write_reg(stv_pkg::CFG_STALE, stale);
    write_reg(stv_pkg::CFG_FUTURE, fut);
  endtask

  // mostly a time-ordered stream near now, mixed with duplicates, regressions,
  // source restarts, clears, bad fields and raw noise
  task automatic queue_stream(input int unsigned n);
    int unsigned              pick;
    logic [stv_pkg::UsW-1:0]  us;
    logic [stv_pkg::UsW-1:0]  base;
    logic [stv_pkg::NowW-1:0] nowv;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      stream_now = stream_now + $urandom_range(1000, 50_000_000);
      base = stream_now / NsPerUs;
      nowv = stream_now;
      us = base;
      if (pick < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          // stamp exactly on now, the only thing a zero window lets through
          nowv = base * NsPerUs;
        end else if ($urandom_range(0, 1) == 1) begin
          us = base + $urandom_range(0, 200_000);
        end else begin
          us = base - $urandom_range(0, 650_000);
        end
        stream_last_us = us;
        queue_sample(OpObserve, us, nowv);
      end else if (pick < 58) begin
        queue_sample(OpObserve, (stream_last_us == '0) ? base : stream_last_us, nowv);
      end else if (pick < 66) begin
        queue_sample(OpObserve, stream_last_us - $urandom_range(1, 3000), nowv);
      end else if (pick < 74) begin
        // source restart: jump back into the low epoch and continue from there
        us = $urandom_range(1_000_000, 59_000_000);
        stream_now = us * NsPerUs + $urandom_range(0, 1000);
        stream_last_us = us;
        queue_sample(OpObserve, us, stream_now);
      end else if (pick < 79) begin
        // leap far past the low epoch so later restarts can qualify
        stream_now = stream_now + 64'd250_000_000_000;
        us = stream_now / NsPerUs;
        stream_last_us = us;
        queue_sample(OpObserve, us, stream_now);
      end else if (pick < 83) begin
        queue_sample(OpClear, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (pick < 87) begin
        if ($urandom_range(0, 2) == 0) nowv = '0;
        else nowv = {1'b1, 31'($urandom), $urandom};
        queue_sample(OpObserve, base, nowv);
      end else if (pick < 91) begin
        case ($urandom_range(0, 2))
          0: us = '0;
          1: us = stv_pkg::MaxUs + 64'd1 + $urandom_range(0, 1000);
          default: us = {1'b1, 31'($urandom), $urandom};
        endcase
        queue_sample(OpObserve, us, nowv);
      end else begin
        us = {$urandom, $urandom} >> $urandom_range(0, 63);
        nowv = {$urandom, $urandom} >> $urandom_range(0, 8);
        queue_sample(OpObserve, us, nowv);
      end
    end
  endtask

  initial begin : stimulus_proc
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OpObserve;
    in_ch.stamp_us = '0;
    in_ch.now_ns = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = stv_pkg::CFG_RESTART_MIN;
    cfg_ch.data = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    stall_req = 0;
    stall_seen = 0;
    tx_gap = 0;
    rx_gap = 0;
    rx_hold = 0;
    samples_queued = 0;
    samples_taken = 0;
    verdicts_checked = 0;
    reg_writes = 0;
    mismatches = 0;
    foreach (event_hits[i]) event_hits[i] = 0;
    stream_now = 64'd100_000_000_000;
    stream_last_us = '0;
    // registers and history come out of reset at their defaults
    win_restart_min = stv_pkg::RestartMinRst;
    win_low_epoch = stv_pkg::LowEpochRst;
    win_stale = stv_pkg::StaleRst;
    win_future = stv_pkg::FutureRst;
    hist_last_ns = '0;
    hist_have_last = 1'b0;
    hist_gen = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: bad now at zero, most negative and minus one
    queue_sample(OpObserve, 64'd1000, '0);
    queue_sample(OpObserve, 64'd1000, {1'b1, 63'd0});
    queue_sample(OpObserve, 64'd1000, '1);
    // conversion edges: zero stamp, one past the largest, all ones
    queue_sample(OpObserve, '0, 64'sd100_000_000_000);
    queue_sample(OpObserve, stv_pkg::MaxUs + 64'd1, 64'sd100_000_000_000);
    queue_sample(OpObserve, '1, 64'sd100_000_000_000);
    // largest stamp at the largest now, then its duplicate and a small step back
    queue_sample(OpObserve, stv_pkg::MaxUs, {1'b0, StampMax});
    queue_sample(OpObserve, stv_pkg::MaxUs, {1'b0, StampMax});
    queue_sample(OpObserve, stv_pkg::MaxUs - 64'd1, {1'b0, StampMax});
    // big jump back into the low epoch counts as a restart
    queue_sample(OpObserve, 64'd30_000_000, 64'sd30_000_000_000);
    queue_sample(OpClear, '0, '0);
    queue_sample(OpObserve, 64'd100_000_000, 64'sd100_000_000_000);
    // stale, future, then age and lead exactly on the limits
    queue_sample(OpObserve, 64'd100_400_000, 64'sd101_000_000_000);
    queue_sample(OpObserve, 64'd101_200_000, 64'sd101_000_000_000);
    queue_sample(OpObserve, 64'd101_500_000, 64'sd102_000_000_000);
    queue_sample(OpObserve, 64'd102_100_000, 64'sd102_000_000_000);
    // restart down to the smallest stamp at the smallest now, and its duplicate
    queue_sample(OpObserve, 64'd1, 64'sd1);
    queue_sample(OpObserve, 64'd1, 64'sd1);
    queue_sample(OpClear, '1, '1);
    queue_sample(OpClear, '0, '0);
    // fresh history: small lead past now is still inside the window
    queue_sample(OpObserve, 64'd1, 64'sd1);
    drain_results();

    // default window, random pacing, a sender pause halfway
    queue_stream(100);
    drain_results();
    queue_stream(100);
    drain_results();

    // everything zero: only stamps exactly on now survive, no restarts possible
    write_window('0, '0, '0, '0);
    queue_stream(80);
    drain_results();

    // everything at the maximum: the window is wide open
    write_window(StampMax, StampMax, StampMax, StampMax);
    queue_stream(80);
    drain_results();

    // random window; the receiver holds off long while the sender keeps pushing
    write_window(63'($urandom_range(0, 2000)) * 63'd1_000_000,
                 63'($urandom_range(10, 200)) * 63'd1_000_000_000,
                 63'($urandom_range(1, 1500)) * 63'd1_000_000,
                 63'($urandom_range(1, 500)) * 63'd1_000_000);
    tx_idle_en = 1'b0;
    stall_req++;
    queue_stream(150);
    drain_results();

    // back to defaults, full speed on both sides
    write_window(stv_pkg::RestartMinRst, stv_pkg::LowEpochRst,
                 stv_pkg::StaleRst, stv_pkg::FutureRst);
    rx_idle_en = 1'b0;
    queue_stream(150);
    drain_results();

    repeat (TailCycles) @(negedge clk_i);
    if (expected_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_verdicts.size()));
      mismatches += expected_verdicts.size() - 1;
    end

    $display("covered %0d samples, %0d results checked, %0d register writes, %0d mismatches",
             samples_taken, verdicts_checked, reg_writes, mismatches);
    $display("events: acc=%0d badnow=%0d badconv=%0d dup=%0d smallreg=%0d restart=%0d %s%0d %s%0d",
             event_hits[stv_pkg::EV_ACCEPTED], event_hits[stv_pkg::EV_BAD_NOW],
             event_hits[stv_pkg::EV_BAD_CONV], event_hits[stv_pkg::EV_DUPLICATE],
             event_hits[stv_pkg::EV_SMALL_REG], event_hits[stv_pkg::EV_RESTART],
             "stale=", event_hits[stv_pkg::EV_STALE],
             "future=", event_hits[stv_pkg::EV_FUTURE]);
    if (mismatches == 0) begin
      $display("sample_timestamp_validator_top regression: pass");
    end else begin
      $display("sample_timestamp_validator_top regression: fail");
    end
    $finish;
  end

endmodule
